// ----- hdl/chimeric_alignment_breakpoint_finder_top_defines.svh -----
// assertion helpers for the breakpoint finder
`ifndef CHIMERIC_ALIGNMENT_BREAKPOINT_FINDER_TOP_DEFINES_SVH
`define CHIMERIC_ALIGNMENT_BREAKPOINT_FINDER_TOP_DEFINES_SVH

// same-cycle implication, ignored while reset is held
`define CABF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored while reset is held
`define CABF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/cabf_pkg.sv -----
package cabf_pkg;

    localparam int MAX_GROUP = 16;
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);
    localparam int ADDR_W    = $clog2(MAX_GROUP);

    localparam int CW  = 16;
    localparam int QW  = 24;
    localparam int GW  = 31;
    localparam int OPW = 32;

    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 160;

    typedef struct packed {
        logic [CW-1:0] chrom;
        logic [QW-1:0] qf;
        logic [QW-1:0] qt;
        logic [GW-1:0] gf;
        logic [GW-1:0] gt;
        logic          eor;
    } in_t;

    // one held segment as kept in the group store
    typedef struct packed {
        logic [CW-1:0] chrom;
        logic [QW-1:0] qlo;
        logic [QW-1:0] qhi;
        logic [GW-1:0] gfrom;
        logic [GW-1:0] gto;
        logic          rev;
        logic          gswap;
    } member_t;

    localparam int MEM_W = $bits(member_t);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        member_t           data;
    } mem_wr_t;

    typedef struct packed {
        logic [OPW-1:0] a;
        logic [OPW-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [OPW-1:0] diff;
        logic           lt;
        logic           eq;
    } alu_res_t;

    typedef struct packed {
        logic [CW-1:0] bp1_chrom;
        logic [GW-1:0] bp1_low;
        logic [GW-1:0] bp1_high;
        logic          bp1_left;
        logic [CW-1:0] bp2_chrom;
        logic [GW-1:0] bp2_low;
        logic [GW-1:0] bp2_high;
        logic          bp2_left;
        logic          last_of_run;
        logic          group_truncated;
    } pair_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             ov;
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_LAST,
        ST_OV_LEN,
        ST_OV_SPA,
        ST_OV_CA,
        ST_OV_SPB,
        ST_OV_CB,
        ST_SC_RD,
        ST_SC_CMP,
        ST_EM_RD,
        ST_EM_OUT,
        ST_EM_HOLD,
        ST_WRITE
    } state_t;

endpackage

// ----- hdl/chimeric_alignment_breakpoint_finder_top.sv -----
// channel  dir  tdata                          tlast        tuser
// s_       in   segment, 126 bits in 128       end_of_read  -
// m_       out  breakpoint pair, 158 in 160    last_of_run  group_truncated
//
// one item at a time; ready only while idle
// empty group: stored directly; overlapping segment: length and span checks, then stored
// non-overlap: every held segment is scanned, then each is emitted as a pair when all
// are discordant; sequenced through the single store read port and the shared subtractor
// reset: synchronous, active low, clears the sequencer, group count, truncation flag and output valid only
// output stalls hold the sequencer in place until the pair is taken
`include "chimeric_alignment_breakpoint_finder_top_defines.svh"

module chimeric_alignment_breakpoint_finder_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // chrom, query_from, query_to, genome_from, genome_to, zero pad
    input  logic [cabf_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // bp1_chrom, bp1_low, bp1_high, bp1_left, bp2_chrom, bp2_low, bp2_high,
    // bp2_left, zero pad
    output logic [cabf_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast,
    // group_truncated
    output logic                             m_tuser
);

    cabf_pkg::in_t                   in_item;
    cabf_pkg::alu_req_t              alu_req;
    cabf_pkg::alu_res_t              alu_res;
    cabf_pkg::mem_wr_t               mem_wr;
    logic [cabf_pkg::ADDR_W-1:0]     mem_raddr;
    logic [cabf_pkg::MEM_W-1:0]      mem_rdata;
    logic                            emit_load;
    cabf_pkg::pair_t                 pair;
    cabf_pkg::status_t               status;
    logic                            out_taken;

    cabf_pkg::pair_t                 pair_reg;
    logic                            out_valid_reg, out_valid_next;

    assign in_item.chrom = s_tdata[15:0];
    assign in_item.qf    = s_tdata[39:16];
    assign in_item.qt    = s_tdata[63:40];
    assign in_item.gf    = s_tdata[94:64];
    assign in_item.gt    = s_tdata[125:95];
    assign in_item.eor   = s_tlast;

    cabf_ram #(
        .WIDTH(cabf_pkg::MEM_W),
        .DEPTH(cabf_pkg::MAX_GROUP)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_wr.we),
        .waddr (mem_wr.addr),
        .wdata (mem_wr.data),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    cabf_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    cabf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_item   (in_item),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .alu_req   (alu_req),
        .alu_res   (alu_res),
        .mem_wr    (mem_wr),
        .mem_raddr (mem_raddr),
        .mem_rdata (cabf_pkg::member_t'(mem_rdata)),
        .emit_load (emit_load),
        .pair      (pair),
        .out_taken (out_taken),
        .status    (status)
    );

    assign out_taken = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit_load) begin
            out_valid_next = 1'b1;
        end else if (out_taken) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (emit_load) begin
            pair_reg <= pair;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       pair_reg.bp2_left, pair_reg.bp2_high, pair_reg.bp2_low,
                       pair_reg.bp2_chrom,
                       pair_reg.bp1_left, pair_reg.bp1_high, pair_reg.bp1_low,
                       pair_reg.bp1_chrom};
    assign m_tlast  = pair_reg.last_of_run;
    assign m_tuser  = pair_reg.group_truncated;

    `CABF_ASSERT_NOW(a_no_accept_while_pending, aclk, aresetn, m_tvalid, !s_tready, "input accepted while a pair is pending")
    `CABF_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "ready after accepting an item")
    `CABF_ASSERT_NOW(a_trunc_only_full, aclk, aresetn, status.ov, status.count == cabf_pkg::CNT_W'(cabf_pkg::MAX_GROUP), "truncation flag set with group not full")
    `CABF_ASSERT_NEXT(a_run_ends, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid, "pair issued after the last of a run")

endmodule

// ----- hdl/cabf_ram.sv -----
module cabf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/cabf_alu.sv -----
module cabf_alu (
    input  cabf_pkg::alu_req_t req,
    output cabf_pkg::alu_res_t res
);

    logic [cabf_pkg::OPW:0] sub;

    assign sub      = {1'b0, req.a} - {1'b0, req.b};
    assign res.diff = sub[cabf_pkg::OPW-1:0];
    assign res.lt   = sub[cabf_pkg::OPW];
    assign res.eq   = (sub[cabf_pkg::OPW-1:0] == '0);

endmodule

// ----- hdl/cabf_ctrl.sv -----
module cabf_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cabf_pkg::in_t                   in_item,
    input  logic                            in_valid,
    output logic                            in_ready,
    output cabf_pkg::alu_req_t              alu_req,
    input  cabf_pkg::alu_res_t              alu_res,
    output cabf_pkg::mem_wr_t               mem_wr,
    output logic [cabf_pkg::ADDR_W-1:0]     mem_raddr,
    input  cabf_pkg::member_t               mem_rdata,
    output logic                            emit_load,
    output cabf_pkg::pair_t                 pair,
    input  logic                            out_taken,
    output cabf_pkg::status_t               status
);

    cabf_pkg::state_t state_reg, state_next;

    logic [cabf_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                        ov_reg, ov_next;
    cabf_pkg::member_t           new_reg, new_next;
    logic                        eor_reg, eor_next;
    logic [cabf_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [cabf_pkg::ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic [cabf_pkg::CNT_W-1:0]  cnt_after_reg, cnt_after_next;
    logic                        ov_after_reg, ov_after_next;
    logic [cabf_pkg::QW-1:0]     len_reg, len_next;
    logic [cabf_pkg::QW-1:0]     tmp_reg, tmp_next;
    logic                        fa_reg, fa_next;
    logic                        any_reg, any_next;

    logic [cabf_pkg::CNT_W-1:0]  cnt_m1;
    logic [cabf_pkg::ADDR_W-1:0] last_idx;
    logic                        at_last;
    logic                        qswap, gswap;
    logic                        c1, c2;
    logic [cabf_pkg::QW-1:0]     mn, lo;
    logic                        nonov;
    logic                        le, ge, ggt, disc, conc;

    assign cnt_m1   = count_reg - cabf_pkg::CNT_W'(1);
    assign last_idx = cnt_m1[cabf_pkg::ADDR_W-1:0];
    assign at_last  = (addr_reg == last_idx);

    assign qswap = (in_item.qf > in_item.qt);
    assign gswap = (in_item.gf > in_item.gt);

    // held segment a is the store output, new segment b is new_reg
    assign c1 = (mem_rdata.qlo <= new_reg.qlo) && (mem_rdata.qhi >= new_reg.qlo);
    assign c2 = (mem_rdata.qlo >= new_reg.qlo) && (mem_rdata.qlo <= new_reg.qhi);
    assign mn = (mem_rdata.qhi < new_reg.qhi) ? mem_rdata.qhi : new_reg.qhi;
    assign lo = (mem_rdata.qlo <= new_reg.qlo) ? new_reg.qlo : mem_rdata.qlo;
    assign nonov = fa_reg && alu_res.lt;

    // concordance, genome compare comes from the shared unit
    assign le   = (mem_rdata.qlo <= new_reg.qlo);
    assign ge   = (mem_rdata.qlo >= new_reg.qlo);
    assign ggt  = !alu_res.lt && !alu_res.eq;
    assign disc = new_reg.rev ? ((le && alu_res.lt) || (ge && ggt))
                              : ((le && ggt) || (ge && alu_res.lt));
    assign conc = (mem_rdata.chrom == new_reg.chrom) && (mem_rdata.rev == new_reg.rev)
                  && !disc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cabf_pkg::ST_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
        new_reg       <= new_next;
        eor_reg       <= eor_next;
        addr_reg      <= addr_next;
        wr_addr_reg   <= wr_addr_next;
        cnt_after_reg <= cnt_after_next;
        ov_after_reg  <= ov_after_next;
        len_reg       <= len_next;
        tmp_reg       <= tmp_next;
        fa_reg        <= fa_next;
        any_reg       <= any_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cabf_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = (count_reg == '0) ? cabf_pkg::ST_WRITE : cabf_pkg::ST_RD_LAST;
                end
            end
            cabf_pkg::ST_RD_LAST: state_next = cabf_pkg::ST_OV_LEN;
            cabf_pkg::ST_OV_LEN:  state_next = cabf_pkg::ST_OV_SPA;
            cabf_pkg::ST_OV_SPA:  state_next = cabf_pkg::ST_OV_CA;
            cabf_pkg::ST_OV_CA:   state_next = cabf_pkg::ST_OV_SPB;
            cabf_pkg::ST_OV_SPB:  state_next = cabf_pkg::ST_OV_CB;
            cabf_pkg::ST_OV_CB: begin
                state_next = nonov ? cabf_pkg::ST_SC_RD : cabf_pkg::ST_WRITE;
            end
            cabf_pkg::ST_SC_RD:   state_next = cabf_pkg::ST_SC_CMP;
            cabf_pkg::ST_SC_CMP: begin
                if (at_last) begin
                    state_next = (any_reg || conc) ? cabf_pkg::ST_WRITE : cabf_pkg::ST_EM_RD;
                end else begin
                    state_next = cabf_pkg::ST_SC_RD;
                end
            end
            cabf_pkg::ST_EM_RD:   state_next = cabf_pkg::ST_EM_OUT;
            cabf_pkg::ST_EM_OUT:  state_next = cabf_pkg::ST_EM_HOLD;
            cabf_pkg::ST_EM_HOLD: begin
                if (out_taken) begin
                    state_next = at_last ? cabf_pkg::ST_WRITE : cabf_pkg::ST_EM_RD;
                end
            end
            cabf_pkg::ST_WRITE:   state_next = cabf_pkg::ST_IDLE;
            default:              state_next = cabf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready     = 1'b0;
        emit_load    = 1'b0;
        alu_req.a    = '0;
        alu_req.b    = '0;
        mem_wr.we    = 1'b0;
        mem_wr.addr  = wr_addr_reg;
        mem_wr.data  = new_reg;
        case (state_reg)
            cabf_pkg::ST_IDLE:    in_ready = 1'b1;
            cabf_pkg::ST_OV_LEN: begin
                alu_req.a = cabf_pkg::OPW'(mn);
                alu_req.b = cabf_pkg::OPW'(lo);
            end
            cabf_pkg::ST_OV_SPA: begin
                alu_req.a = cabf_pkg::OPW'(mem_rdata.qhi);
                alu_req.b = cabf_pkg::OPW'(mem_rdata.qlo);
            end
            cabf_pkg::ST_OV_CA, cabf_pkg::ST_OV_CB: begin
                alu_req.a = cabf_pkg::OPW'({len_reg, 2'b00});
                alu_req.b = cabf_pkg::OPW'(tmp_reg);
            end
            cabf_pkg::ST_OV_SPB: begin
                alu_req.a = cabf_pkg::OPW'(new_reg.qhi);
                alu_req.b = cabf_pkg::OPW'(new_reg.qlo);
            end
            cabf_pkg::ST_SC_CMP: begin
                alu_req.a = cabf_pkg::OPW'(mem_rdata.gfrom);
                alu_req.b = cabf_pkg::OPW'(new_reg.gfrom);
            end
            cabf_pkg::ST_EM_OUT:  emit_load = 1'b1;
            cabf_pkg::ST_WRITE:   mem_wr.we = 1'b1;
            default: begin
            end
        endcase
    end

    always_comb begin
        count_next     = count_reg;
        ov_next        = ov_reg;
        new_next       = new_reg;
        eor_next       = eor_reg;
        addr_next      = addr_reg;
        wr_addr_next   = wr_addr_reg;
        cnt_after_next = cnt_after_reg;
        ov_after_next  = ov_after_reg;
        len_next       = len_reg;
        tmp_next       = tmp_reg;
        fa_next        = fa_reg;
        any_next       = any_reg;
        case (state_reg)
            cabf_pkg::ST_IDLE: begin
                if (in_valid) begin
                    new_next.chrom = in_item.chrom;
                    new_next.qlo   = qswap ? in_item.qt : in_item.qf;
                    new_next.qhi   = qswap ? in_item.qf : in_item.qt;
                    new_next.gfrom = in_item.gf;
                    new_next.gto   = in_item.gt;
                    new_next.rev   = qswap ^ gswap;
                    new_next.gswap = gswap;
                    eor_next       = in_item.eor;
                    addr_next      = last_idx;
                    wr_addr_next   = '0;
                    cnt_after_next = cabf_pkg::CNT_W'(1);
                    ov_after_next  = 1'b0;
                end
            end
            cabf_pkg::ST_OV_LEN: len_next = (c1 || c2) ? alu_res.diff[cabf_pkg::QW-1:0] : '0;
            cabf_pkg::ST_OV_SPA: tmp_next = alu_res.diff[cabf_pkg::QW-1:0];
            cabf_pkg::ST_OV_CA:  fa_next  = alu_res.lt;
            cabf_pkg::ST_OV_SPB: tmp_next = alu_res.diff[cabf_pkg::QW-1:0];
            cabf_pkg::ST_OV_CB: begin
                if (!nonov) begin
                    // joins the group, or overwrites the final slot when full
                    if (count_reg < cabf_pkg::CNT_W'(cabf_pkg::MAX_GROUP)) begin
                        wr_addr_next   = count_reg[cabf_pkg::ADDR_W-1:0];
                        cnt_after_next = count_reg + cabf_pkg::CNT_W'(1);
                        ov_after_next  = ov_reg;
                    end else begin
                        wr_addr_next   = cabf_pkg::ADDR_W'(cabf_pkg::MAX_GROUP - 1);
                        cnt_after_next = count_reg;
                        ov_after_next  = 1'b1;
                    end
                end else begin
                    addr_next      = '0;
                    any_next       = 1'b0;
                    wr_addr_next   = '0;
                    cnt_after_next = cabf_pkg::CNT_W'(1);
                    ov_after_next  = 1'b0;
                end
            end
            cabf_pkg::ST_SC_CMP: begin
                any_next  = any_reg || conc;
                addr_next = at_last ? '0 : addr_reg + cabf_pkg::ADDR_W'(1);
            end
            cabf_pkg::ST_EM_HOLD: begin
                if (out_taken && !at_last) begin
                    addr_next = addr_reg + cabf_pkg::ADDR_W'(1);
                end
            end
            cabf_pkg::ST_WRITE: begin
                count_next = eor_reg ? '0 : cnt_after_reg;
                ov_next    = eor_reg ? 1'b0 : ov_after_reg;
            end
            default: begin
            end
        endcase
    end

    assign mem_raddr = addr_reg;

    always_comb begin
        pair.bp1_chrom       = mem_rdata.chrom;
        pair.bp1_low         = mem_rdata.gswap ? mem_rdata.gto : mem_rdata.gfrom;
        pair.bp1_high        = mem_rdata.gswap ? mem_rdata.gfrom : mem_rdata.gto;
        pair.bp1_left        = mem_rdata.rev;
        pair.bp2_chrom       = new_reg.chrom;
        pair.bp2_low         = new_reg.gswap ? new_reg.gto : new_reg.gfrom;
        pair.bp2_high        = new_reg.gswap ? new_reg.gfrom : new_reg.gto;
        pair.bp2_left        = !new_reg.rev;
        pair.last_of_run     = at_last;
        pair.group_truncated = ov_reg;
    end

    assign status.count = count_reg;
    assign status.ov    = ov_reg;

endmodule
